// ----- rtl/core/hcbp_pkg.sv -----
// Shared constants and types for the code bit packer.
// No dependencies; imported by huffman_code_bit_packer_top.
package hcbp_pkg;

    localparam int BYTE_W           = 8;
    localparam int CMD_W            = 2;
    localparam int SYM_FIELD_W      = 7;
    localparam int CODE_FIELD_W     = 16;
    localparam int LEN_FIELD_W      = 5;
    localparam int SYM_WIDE_W       = 8;
    localparam int PEND_W           = 4;
    localparam int RES_DEPTH        = 4;
    localparam int RES_PTR_W        = 2;
    localparam int RES_CNT_W        = 3;
    localparam int DEF_MAX_CODE_LEN = 16;
    localparam int DEF_SYMBOL_COUNT = 128;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } res_t;

endpackage

// ----- rtl/core/huffman_code_bit_packer_top.sv -----
// Code bit packer: code table, bit accumulator and result queue.
// Depends on hcbp_pkg.
//
// One command beat is taken per cycle unless stage 1 waits for queue room. A beat
// reads the code table at acceptance (loads write it at the same edge), is packed
// from the stage-1 registers into a four-entry result queue, and its first byte is
// offered after those ahead of it. The result port moves one byte per cycle while
// res_ready is high, so an encode that releases two bytes, or a flush, takes two
// port transfers, and the result port sets the sustained rate. The table resets to
// all-zero through per-entry valid bits, so there is no clearing pass after reset.
module huffman_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  logic [hcbp_pkg::CMD_W-1:0]         command,
    input  logic [hcbp_pkg::SYM_FIELD_W-1:0]   symbol,
    input  logic [hcbp_pkg::CODE_FIELD_W-1:0]  code_bits,
    input  logic [hcbp_pkg::LEN_FIELD_W-1:0]   code_length,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
    output logic                               last
);
    import hcbp_pkg::*;

    localparam int CODE_LIMIT = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    localparam int LEN_W      = $clog2(CODE_LIMIT + 1);
    localparam int IDX_W      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ACC_W      = BYTE_W + CODE_LIMIT;
    localparam int TOT_W      = $clog2(ACC_W + 1);

    // input side and table access
    logic                     cmd_fire;
    logic                     sym_ok;
    logic [SYM_WIDE_W-1:0]    sym_wide;
    logic [IDX_W-1:0]         sym_idx;
    logic                     load_we;
    logic                     rd_en;
    logic [LEN_FIELD_W-1:0]   len_sat;
    logic [CODE_FIELD_W-1:0]  code_mask;
    logic [CODE_FIELD_W-1:0]  code_masked;

    logic [CODE_LIMIT-1:0]    code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]  entry_ok_reg;
    logic [SYMBOL_COUNT-1:0]  entry_ok_next;

    logic [CODE_LIMIT-1:0]    rd_code_reg;
    logic [LEN_W-1:0]         rd_len_reg;
    logic                     rd_ok_reg;

    // packing stage
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_encode_reg;
    logic                     s1_flush_reg;
    logic                     s1_go;

    logic [BYTE_W-1:0]        acc_reg;
    logic [BYTE_W-1:0]        acc_next;
    logic [PEND_W-1:0]        pend_reg;
    logic [PEND_W-1:0]        pend_next;

    logic [LEN_W-1:0]         ent_len;
    logic [CODE_LIMIT-1:0]    ent_code;
    logic [TOT_W-1:0]         total;
    logic [ACC_W-1:0]         wide;
    logic                     has0;
    logic                     has1;
    logic [BYTE_W-1:0]        byte0;
    logic [BYTE_W-1:0]        byte1;
    logic [PEND_W-1:0]        enc_pend;
    logic [PEND_W-1:0]        pad;

    // result queue
    res_t                     res_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]     wr_ptr_reg;
    logic [RES_PTR_W-1:0]     wr_ptr_next;
    logic [RES_PTR_W-1:0]     rd_ptr_reg;
    logic [RES_PTR_W-1:0]     rd_ptr_next;
    logic [RES_CNT_W-1:0]     cnt_reg;
    logic [RES_CNT_W-1:0]     cnt_next;
    logic [1:0]               push_n;
    res_t                     push0;
    res_t                     push1;
    logic                     pop;

    // ---------------------------------------------------------------- input
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign sym_ok    = ((SYM_WIDE_W + 1)'(symbol) < (SYM_WIDE_W + 1)'(SYMBOL_COUNT));
    assign sym_wide  = SYM_WIDE_W'(symbol);
    assign sym_idx   = sym_wide[IDX_W-1:0];
    assign load_we   = cmd_fire && (command == CMD_LOAD) && sym_ok;
    assign rd_en     = cmd_fire && (command == CMD_ENCODE) && sym_ok;

    // saturate the length, then drop code bits above it
    assign len_sat     = (code_length > LEN_FIELD_W'(CODE_LIMIT)) ?
                         LEN_FIELD_W'(CODE_LIMIT) : code_length;
    assign code_mask   = ~({CODE_FIELD_W{1'b1}} << len_sat);
    assign code_masked = code_bits & code_mask;

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            code_mem[sym_idx] <= code_masked[CODE_LIMIT-1:0];
            len_mem[sym_idx]  <= len_sat[LEN_W-1:0];
        end
        if (rd_en)
        begin
            rd_code_reg <= code_mem[sym_idx];
            rd_len_reg  <= len_mem[sym_idx];
            rd_ok_reg   <= entry_ok_reg[sym_idx];
        end
    end

    always_comb
    begin
        entry_ok_next = entry_ok_reg;
        if (load_we)
        begin
            entry_ok_next[sym_idx] = 1'b1;
        end
    end

    // ---------------------------------------------------------------- stage 1
    assign s1_go     = s1_valid_reg &&
                       (!(s1_encode_reg || s1_flush_reg) || (cnt_reg <= RES_CNT_W'(2)));
    assign cmd_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_encode_reg <= (command == CMD_ENCODE) && sym_ok;
            s1_flush_reg  <= (command == CMD_FLUSH);
        end
    end

    // never-written entries read as an empty code
    assign ent_len  = rd_ok_reg ? rd_len_reg  : '0;
    assign ent_code = rd_ok_reg ? rd_code_reg : '0;

    assign total = TOT_W'(pend_reg) + TOT_W'(ent_len);
    assign wide  = (ACC_W'(acc_reg) << ent_len) | ACC_W'(ent_code);
    assign has0  = (int'(total) > BYTE_W);
    assign has1  = (int'(total) > 2 * BYTE_W);
    assign byte0 = BYTE_W'(wide >> (total - TOT_W'(BYTE_W)));
    assign byte1 = BYTE_W'(wide >> (total - TOT_W'(2 * BYTE_W)));
    assign pad   = PEND_W'(BYTE_W) - pend_reg;

    always_comb
    begin
        priority if (has1)
        begin
            enc_pend = PEND_W'(total - TOT_W'(2 * BYTE_W));
        end
        else if (has0)
        begin
            enc_pend = PEND_W'(total - TOT_W'(BYTE_W));
        end
        else
        begin
            enc_pend = PEND_W'(total);
        end
    end

    always_comb
    begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        push_n     = 2'd0;
        push0      = '0;
        push1      = '0;
        if (s1_go && s1_encode_reg)
        begin
            // keep only the bits still held
            acc_next  = wide[BYTE_W-1:0] & ~({BYTE_W{1'b1}} << enc_pend);
            pend_next = enc_pend;
            if (has1)
            begin
                push_n = 2'd2;
                push0  = '{data: byte0, last: 1'b0};
                push1  = '{data: byte1, last: 1'b1};
            end
            else if (has0)
            begin
                push_n = 2'd1;
                push0  = '{data: byte0, last: 1'b1};
            end
        end
        else if (s1_go && s1_flush_reg)
        begin
            acc_next  = '0;
            pend_next = '0;
            push_n    = 2'd2;
            push0     = '{data: acc_reg << pad, last: 1'b0};
            push1     = '{data: BYTE_W'(pad), last: 1'b1};
        end
    end

    // ---------------------------------------------------------------- results
    assign pop       = res_valid && res_ready;
    assign res_valid = (cnt_reg != '0);
    assign out_byte  = res_mem[rd_ptr_reg].data;
    assign last      = res_mem[rd_ptr_reg].last;

    assign wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
    assign cnt_next    = cnt_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            res_mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            res_mem[wr_ptr_reg + RES_PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_ok_reg <= '0;
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            pend_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            entry_ok_reg <= entry_ok_next;
            s1_valid_reg <= s1_valid_next;
            acc_reg      <= acc_next;
            pend_reg     <= pend_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

    // ---------------------------------------------------------------- checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue over its depth");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(BYTE_W))
        else $error("more than one byte held between beats");

    a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> pend_reg) == '0)
        else $error("stale bits above the held bits");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_flush_reg) |=> (pend_reg == '0) && (acc_reg == '0))
        else $error("flush left bits in the accumulator");

endmodule

// ----- tb/huffman_code_bit_packer_top_tb.sv -----
// Self-checking bench for huffman_code_bit_packer_top: sends load, encode and flush beats
// and checks every packed byte against a bit packer model kept inside the bench.
// Depends on hcbp_pkg and the packer RTL; reads no files.
module huffman_code_bit_packer_top_tb;
    import hcbp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_LEN =
        (DEF_MAX_CODE_LEN < CODE_FIELD_W) ? DEF_MAX_CODE_LEN : CODE_FIELD_W;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cmd_valid   = 1'b0;
    logic                    cmd_ready;
    logic [CMD_W-1:0]        command     = CMD_LOAD;
    logic [SYM_FIELD_W-1:0]  symbol      = '0;
    logic [CODE_FIELD_W-1:0] code_bits   = '0;
    logic [LEN_FIELD_W-1:0]  code_length = '0;
    logic                    res_valid;
    logic                    res_ready   = 1'b0;
    logic [BYTE_W-1:0]       out_byte;
    logic                    last;

    // Model state: code table, bit accumulator and count of held bits
    logic [CODE_FIELD_W-1:0] code_mem [DEF_SYMBOL_COUNT];
    logic [LEN_FIELD_W-1:0]  len_mem  [DEF_SYMBOL_COUNT];
    logic [23:0]             acc_bits;
    int                      held_count;

    res_t packed_due [$];
    int   errors        = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic stalling      = 1'b0;
    event hold_start;

    huffman_code_bit_packer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [31:0] low_ones(input int n);
        return (n >= 32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
    endfunction

    // Update the model with one accepted beat and queue the bytes it releases
    task automatic pack_command(input logic [CMD_W-1:0] cmd,
                                input logic [SYM_FIELD_W-1:0] sym,
                                input logic [CODE_FIELD_W-1:0] code,
                                input logic [LEN_FIELD_W-1:0] len);
        int   n_len;
        int   n_out;
        int   held;
        int   pad;
        res_t r;
        n_len = len;
        case (cmd)
            CMD_LOAD:
            begin
                if (n_len > MAX_LEN)
                    n_len = MAX_LEN;
                len_mem[sym]  = LEN_FIELD_W'(n_len);
                code_mem[sym] = CODE_FIELD_W'(code & low_ones(n_len));
            end
            CMD_ENCODE:
            begin
                n_len = len_mem[sym];
                if (n_len > 0)
                begin
                    acc_bits   = (acc_bits << n_len) | code_mem[sym];
                    held_count += n_len;
                end
                n_out = 0;
                // Release the oldest eight bits while more than a byte is held
                while (held_count > 8 && n_out < 2)
                begin
                    held_count -= 8;
                    r.data   = BYTE_W'(acc_bits >> held_count);
                    r.last   = 1'b0;
                    acc_bits = acc_bits & 24'(low_ones(held_count));
                    packed_due.push_back(r);
                    n_out++;
                end
                if (n_out > 0)
                begin
                    r = packed_due.pop_back();
                    r.last = 1'b1;
                    packed_due.push_back(r);
                end
            end
            CMD_FLUSH:
            begin
                held   = (held_count > 8) ? 8 : held_count;
                pad    = 8 - held;
                r.data = BYTE_W'((acc_bits & low_ones(held)) << pad);
                r.last = 1'b0;
                packed_due.push_back(r);
                r.data = BYTE_W'(pad);
                r.last = 1'b1;
                packed_due.push_back(r);
                acc_bits   = '0;
                held_count = 0;
            end
            default: ;
        endcase
    endtask

    // Offer one beat, hold it until accepted, then predict its bytes
    task automatic send_beat(input logic [CMD_W-1:0] cmd,
                             input logic [SYM_FIELD_W-1:0] sym,
                             input logic [CODE_FIELD_W-1:0] code,
                             input logic [LEN_FIELD_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        command     <= cmd;
        symbol      <= sym;
        code_bits   <= code;
        code_length <= len;
        do
            @(posedge clk);
        while (!cmd_ready);
        pack_command(cmd, sym, code, len);
    endtask

    always @(posedge clk)
    begin
        res_ready <= !stalling && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin
        forever
        begin
            @(hold_start);
            stalling = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            stalling = 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_bytes
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (packed_due.size() == 0)
            begin
                errors++;
                $display("%0t: expected no byte, got out_byte %02h last %0b",
                         $time, out_byte, last);
            end
            else
            begin
                want = packed_due.pop_front();
                if (out_byte !== want.data)
                begin
                    errors++;
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, want.data, out_byte);
                end
                if (last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0b, got %0b",
                             $time, want.last, last);
                end
            end
        end
    end

    // Extremes of every field, all commands and each corner of the packer
    task automatic test_directed();
        send_beat(CMD_FLUSH,  7'd0,   16'h0000, 5'd0);   // flush with nothing held
        send_beat(CMD_ENCODE, 7'd100, 16'hFFFF, 5'd31);  // symbol never loaded
        send_beat(CMD_LOAD,   7'd0,   16'hFFFF, 5'd16);
        send_beat(CMD_LOAD,   7'd127, 16'h0001, 5'd1);
        send_beat(CMD_LOAD,   7'd7,   16'h005A, 5'd8);
        send_beat(CMD_LOAD,   7'd9,   16'hFFFF, 5'd3);   // code masked to its length
        send_beat(CMD_LOAD,   7'd5,   16'hFFFF, 5'd31);  // length saturates
        send_beat(CMD_LOAD,   7'd6,   16'hABCD, 5'd0);
        send_beat(CMD_LOAD,   7'd10,  16'h1234, 5'd17);
        send_beat(CMD_ENCODE, 7'd7,   16'h0000, 5'd0);
        send_beat(CMD_FLUSH,  7'd0,   16'h0000, 5'd0);   // exactly eight bits held
        send_beat(CMD_ENCODE, 7'd0,   16'h0000, 5'd0);
        send_beat(CMD_ENCODE, 7'd0,   16'h0000, 5'd0);   // two bytes from one beat
        send_beat(CMD_ENCODE, 7'd6,   16'h0000, 5'd0);   // empty code
        send_beat(CMD_ENCODE, 7'd127, 16'h0000, 5'd0);
        send_beat(CMD_ENCODE, 7'd9,   16'h0000, 5'd0);
        send_beat(CMD_ENCODE, 7'd5,   16'h0000, 5'd0);
        send_beat(CMD_ENCODE, 7'd10,  16'h0000, 5'd0);
        send_beat(CMD_UNUSED, 7'd127, 16'hFFFF, 5'd31);
        send_beat(CMD_FLUSH,  7'd127, 16'hFFFF, 5'd31);
        send_beat(CMD_ENCODE, 7'd127, 16'h0000, 5'd0);
        send_beat(CMD_FLUSH,  7'd0,   16'h0000, 5'd0);   // one bit held, seven pad
        send_beat(CMD_LOAD,   7'd0,   16'h0000, 5'd0);
        send_beat(CMD_ENCODE, 7'd0,   16'h0000, 5'd0);
        send_beat(CMD_FLUSH,  7'd0,   16'h0000, 5'd0);
    endtask

    // Fill the table, then a random mix weighted towards encodes
    task automatic test_random_mix(input int n_items, input int s_pct, input int r_pct);
        int                     pick;
        logic [CMD_W-1:0]       cmd;
        logic [LEN_FIELD_W-1:0] len;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int s = 0; s < DEF_SYMBOL_COUNT; s++)
            send_beat(CMD_LOAD, SYM_FIELD_W'(s), CODE_FIELD_W'($urandom_range(16'hFFFF)),
                      LEN_FIELD_W'($urandom_range(1, MAX_LEN)));
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? LEN_FIELD_W'($urandom_range(31))
                                            : LEN_FIELD_W'($urandom_range(1, MAX_LEN));
            if (pick < 14)
                cmd = CMD_LOAD;
            else if (pick < 90)
                cmd = CMD_ENCODE;
            else if (pick < 98)
                cmd = CMD_FLUSH;
            else
                cmd = CMD_UNUSED;
            send_beat(cmd, SYM_FIELD_W'($urandom_range(127)),
                      CODE_FIELD_W'($urandom_range(16'hFFFF)), len);
        end
    endtask

    // Stall the result side long enough for the block to back up its input
    task automatic test_long_hold();
        send_beat(CMD_LOAD, 7'd1, CODE_FIELD_W'($urandom_range(16'hFFFF)),
                  LEN_FIELD_W'(MAX_LEN));
        -> hold_start;
        repeat (40) send_beat(CMD_ENCODE, 7'd1, 16'h0000, 5'd0);
    endtask

    initial
    begin
        for (int i = 0; i < DEF_SYMBOL_COUNT; i++)
        begin
            code_mem[i] = '0;
            len_mem[i]  = '0;
        end
        acc_bits   = '0;
        held_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(400, 25, 56);
        test_random_mix(400, 56, 25);
        test_random_mix(400, 0, 0);
        test_long_hold();

        cmd_valid <= 1'b0;
        while (packed_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && packed_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- huffman_code_bit_packer_top.f -----
rtl/core/hcbp_pkg.sv
rtl/core/huffman_code_bit_packer_top.sv
tb/huffman_code_bit_packer_top_tb.sv
